>>> rtl/ostt_pkg.sv
// Package with the word types, codes and constants of the one-shot timer table.
package ostt_pkg;

   // Default depth of the timer table.
   localparam int MAX_TIMERS_DEF = 16;

   // Request actions.
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_SET    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   // Response event kinds.
   localparam logic [2:0] EV_SET_ACK    = 3'd0;
   localparam logic [2:0] EV_REMOVE_ACK = 3'd1;
   localparam logic [2:0] EV_CLEAR_ACK  = 3'd2;
   localparam logic [2:0] EV_FIRED      = 3'd3;
   localparam logic [2:0] EV_TICK_DONE  = 3'd4;

   // Request word.
   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] increment_ms;
      logic [30:0] duration_ms;
      logic [7:0]  timer_kind;
      logic [31:0] target_id;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [2:0]  event_kind;
      logic [31:0] event_id;
      logic [7:0]  event_type;
      logic [31:0] time_now;
      logic        table_full;
      logic        last;
   } rsp_type;

   // One stored timer.
   typedef struct packed {
      logic [31:0] deadline;
      logic [7:0]  tag;
      logic [31:0] ident;
      logic        cancelled;
   } entry_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET,
      ST_CLEAR,
      ST_REMOVE,
      ST_REMOVE_ACK,
      ST_TICK,
      ST_TICK_DONE
   } state_type;

endpackage

>>> rtl/ostt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ostt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/one_shot_timer_table.sv
// Top level of the one-shot timer table: sequencer, clock, ID counter and response register.
//
// Requests arrive as one word on req_valid/req_word and are taken when req_stall is low.
// The block works on one request at a time; req_stall is high from the cycle after a word
// is taken until its last response has been loaded into the output register.
// Responses leave as words on rsp_valid/rsp_word; a word is held while rsp_stall is high,
// and the last response of each request carries last = 1.
// A set, clear or remove answers with a single word. A tick answers with one fired word per
// due timer, in table order, and then a done word.
// A remove or a tick walks the table memory through its single read port, one entry a
// cycle while no fired word waits on a busy output register; the walk primes the read
// before the first entry and sees that it has ended after the last, and a tick writes
// the surviving entries back in order through the write port. While rsp_stall holds a
// pending response, no further response is loaded.
// Reset clears the clock to 0, the ID counter to 1 and the entry count to 0; the table
// memory needs no clearing pass, as only entries below the count are ever read.
module one_shot_timer_table #(
   parameter int MAX_TIMERS = ostt_pkg::MAX_TIMERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ostt_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ostt_pkg::rsp_type rsp_word
);

   localparam int AW = MAX_TIMERS > 1 ? $clog2(MAX_TIMERS) : 1;
   localparam int CW = $clog2(MAX_TIMERS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TIMERS);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   ostt_pkg::state_type state_ff, state_in;
   ostt_pkg::req_type   req_ff, req_in;
   ostt_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         time_ff, time_in;
   logic [31:0]         id_ff, id_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]       keep_ff, keep_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       data_idx_ff, data_idx_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr;
   ostt_pkg::entry_type   wr_entry, rd_entry;
   logic [$bits(ostt_pkg::entry_type)-1:0] rd_raw;

   logic        req_take, out_free, rsp_load;
   logic        more, due, match, consume;
   logic [31:0] diff;

   // Table memory.
   ostt_ram #(
      .WIDTH ($bits(ostt_pkg::entry_type)),
      .DEPTH (MAX_TIMERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_entry = ostt_pkg::entry_type'(rd_raw);

   // Handshake terms and entry tests.
   assign req_stall = (state_ff != ostt_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign more      = (rd_idx_ff < count_ff);
   assign diff      = rd_entry.deadline - time_ff;
   assign due       = (diff == 32'd0) || diff[31];
   assign match     = pend_ff && (rd_entry.ident == req_ff.target_id);

   // A fetched entry may be retired unless it fires while the output is busy.
   always_comb begin
      if (state_ff == ostt_pkg::ST_TICK) begin
         consume = pend_ff && (rd_entry.cancelled || !due || out_free);
      end else begin
         consume = pend_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ostt_pkg::ST_IDLE: begin
            if (req_take) begin
               unique case (req_word.action)
                  ostt_pkg::ACT_TICK:   state_in = ostt_pkg::ST_TICK;
                  ostt_pkg::ACT_SET:    state_in = ostt_pkg::ST_SET;
                  ostt_pkg::ACT_REMOVE: state_in = ostt_pkg::ST_REMOVE;
                  ostt_pkg::ACT_CLEAR:  state_in = ostt_pkg::ST_CLEAR;
                  default:              state_in = ostt_pkg::ST_IDLE;
               endcase
            end
         end
         ostt_pkg::ST_SET, ostt_pkg::ST_CLEAR,
         ostt_pkg::ST_REMOVE_ACK, ostt_pkg::ST_TICK_DONE: begin
            if (out_free) begin
               state_in = ostt_pkg::ST_IDLE;
            end
         end
         ostt_pkg::ST_REMOVE: begin
            if (match || (!pend_ff && !more)) begin
               state_in = ostt_pkg::ST_REMOVE_ACK;
            end
         end
         ostt_pkg::ST_TICK: begin
            if (!pend_ff && !more) begin
               state_in = ostt_pkg::ST_TICK_DONE;
            end
         end
         default: state_in = ostt_pkg::ST_IDLE;
      endcase
   end

   // Datapath control and response assembly.
   always_comb begin
      req_in      = req_ff;
      time_in     = time_ff;
      id_in       = id_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      keep_in     = keep_ff;
      pend_in     = pend_ff;
      data_idx_in = data_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = keep_ff[AW-1:0];
      wr_entry    = rd_entry;
      rd_en       = 1'b0;
      rsp_load    = 1'b0;
      rsp_in      = rsp_ff;
      rsp_in.time_now = time_ff;

      unique case (state_ff)
         ostt_pkg::ST_IDLE: begin
            if (req_take) begin
               req_in    = req_word;
               rd_idx_in = '0;
               keep_in   = '0;
               pend_in   = 1'b0;
               if (req_word.action == ostt_pkg::ACT_TICK) begin
                  time_in = time_ff + {16'd0, req_word.increment_ms};
               end
            end
         end
         ostt_pkg::ST_SET: begin
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_in.event_kind = ostt_pkg::EV_SET_ACK;
               rsp_in.event_type = 8'd0;
               rsp_in.last       = 1'b1;
               if (count_ff == MAX_CNT) begin
                  rsp_in.event_id   = 32'd0;
                  rsp_in.table_full = 1'b1;
               end else begin
                  wr_en              = 1'b1;
                  wr_addr            = count_ff[AW-1:0];
                  wr_entry.deadline  = time_ff + {1'b0, req_ff.duration_ms};
                  wr_entry.tag       = req_ff.timer_kind;
                  wr_entry.ident     = id_ff + 32'd1;
                  wr_entry.cancelled = 1'b0;
                  id_in              = id_ff + 32'd1;
                  count_in           = count_ff + CNT_ONE;
                  rsp_in.event_id    = id_ff + 32'd1;
                  rsp_in.table_full  = 1'b0;
               end
            end
         end
         ostt_pkg::ST_CLEAR: begin
            if (out_free) begin
               count_in          = '0;
               rsp_load          = 1'b1;
               rsp_in.event_kind = ostt_pkg::EV_CLEAR_ACK;
               rsp_in.event_id   = 32'd0;
               rsp_in.event_type = 8'd0;
               rsp_in.table_full = 1'b0;
               rsp_in.last       = 1'b1;
            end
         end
         ostt_pkg::ST_REMOVE: begin
            // Search in order; the first hit is written back as cancelled.
            if (match) begin
               wr_en              = 1'b1;
               wr_addr            = data_idx_ff;
               wr_entry.cancelled = 1'b1;
               pend_in            = 1'b0;
            end else begin
               rd_en = more;
               if (more) begin
                  pend_in     = 1'b1;
                  data_idx_in = rd_idx_ff[AW-1:0];
                  rd_idx_in   = rd_idx_ff + CNT_ONE;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end
         ostt_pkg::ST_REMOVE_ACK: begin
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_in.event_kind = ostt_pkg::EV_REMOVE_ACK;
               rsp_in.event_id   = 32'd0;
               rsp_in.event_type = 8'd0;
               rsp_in.table_full = 1'b0;
               rsp_in.last       = 1'b1;
            end
         end
         ostt_pkg::ST_TICK: begin
            // Retire the fetched entry: drop, fire or compact it.
            if (consume && !rd_entry.cancelled) begin
               if (due) begin
                  rsp_load          = 1'b1;
                  rsp_in.event_kind = ostt_pkg::EV_FIRED;
                  rsp_in.event_id   = rd_entry.ident;
                  rsp_in.event_type = rd_entry.tag;
                  rsp_in.table_full = 1'b0;
                  rsp_in.last       = 1'b0;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = keep_ff[AW-1:0];
                  keep_in = keep_ff + CNT_ONE;
               end
            end
            // Fetch the next entry once the data register is free.
            if (more && (!pend_ff || consume)) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               data_idx_in = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + CNT_ONE;
            end else if (consume) begin
               pend_in = 1'b0;
            end
            if (!pend_ff && !more) begin
               count_in = keep_ff;
            end
         end
         ostt_pkg::ST_TICK_DONE: begin
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_in.event_kind = ostt_pkg::EV_TICK_DONE;
               rsp_in.event_id   = 32'd0;
               rsp_in.event_type = 8'd0;
               rsp_in.table_full = 1'b0;
               rsp_in.last       = 1'b1;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ostt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         time_ff      <= 32'd0;
         id_ff        <= 32'd1;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         keep_ff      <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
         id_ff        <= id_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         keep_ff      <= keep_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      data_idx_ff <= data_idx_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   // The entry count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count exceeds table depth");

   // Compaction never overtakes the read pointer during a tick.
   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ostt_pkg::ST_TICK) |-> (keep_ff <= rd_idx_ff))
      else $error("compaction pointer passed read pointer");

   // A write-back never hits the entry being fetched in the same cycle.
   a_no_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_idx_ff[AW-1:0]))
      else $error("table write and read collide");

   // A taken request always starts work on the next cycle.
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ostt_pkg::ST_IDLE))
      else $error("request taken but sequencer stayed idle");
`endif

endmodule

>>> tb/sv/tb_one_shot_timer_table.sv
// Self-checking testbench of the one-shot timer table: directed and random words under random stalls.
module tb_one_shot_timer_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH    = ostt_pkg::MAX_TIMERS_DEF;
   localparam int DIRECTED_ITEMS = 27;
   localparam int RANDOM_ITEMS   = 500;
   localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
   // A full tick walks every entry, so the quiet spell after the drain covers any straggling word.
   localparam int SETTLE_CYCLES  = 60;
   localparam int TIMEOUT_NS     = 20_000_000;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ostt_pkg::req_type req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ostt_pkg::rsp_type rsp_word;

   // Words waiting to be offered and events still owed by the block.
   ostt_pkg::req_type pending_words[$];
   ostt_pkg::rsp_type expected_events[$];
   ostt_pkg::rsp_type want_event;

   int accepted_words = 0;
   int mismatch_count = 0;
   int phase          = 0;

   // Idle percentages per phase of the run: sender first, then the receiver.
   int sender_idle[3]   = '{38, 59, 0};
   int receiver_idle[3] = '{59, 38, 0};

   // Predicted state of the timer table.
   logic [31:0]         model_now     = 32'd0;
   logic [31:0]         model_last_id = 32'd1;
   ostt_pkg::entry_type model_table[TABLE_DEPTH];
   int                  model_count   = 0;

   one_shot_timer_table #(
      .MAX_TIMERS(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   // Free-running clock of 20 ns.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Reset is held high from the start of the run and then released at a clock edge.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Builds one event word stamped with the predicted clock.
   function automatic ostt_pkg::rsp_type make_event(input logic [2:0] kind,
                                                    input logic [31:0] id,
                                                    input logic [7:0] tag, input logic full,
                                                    input logic fin);
      ostt_pkg::rsp_type e;
      e.event_kind = kind;
      e.event_id   = id;
      e.event_type = tag;
      e.time_now   = model_now;
      e.table_full = full;
      e.last       = fin;
      return e;
   endfunction

   // Appends one predicted event to the queue of events still owed.
   task automatic append_event(input ostt_pkg::rsp_type e);
      expected_events.insert(expected_events.size(), e);
   endtask

   // Updates the predicted table for one accepted word and queues the events it causes.
   task automatic predict_events(input ostt_pkg::req_type w);
      int          keep;
      logic [31:0] gap;
      bit          hit;
      keep = 0;
      hit  = 1'b0;
      case (w.action)
         ostt_pkg::ACT_SET: begin
            if (model_count >= TABLE_DEPTH) begin
               append_event(make_event(ostt_pkg::EV_SET_ACK, 32'd0, 8'd0, 1'b1, 1'b1));
            end else begin
               model_last_id = model_last_id + 32'd1;
               model_table[model_count].deadline  = model_now + {1'b0, w.duration_ms};
               model_table[model_count].tag       = w.timer_kind;
               model_table[model_count].ident     = model_last_id;
               model_table[model_count].cancelled = 1'b0;
               model_count++;
               append_event(make_event(ostt_pkg::EV_SET_ACK, model_last_id, 8'd0,
                                       1'b0, 1'b1));
            end
         end
         ostt_pkg::ACT_REMOVE: begin
            // Only the first entry carrying the ID is marked.
            for (int i = 0; i < model_count; i++) begin
               if (!hit && model_table[i].ident == w.target_id) begin
                  model_table[i].cancelled = 1'b1;
                  hit = 1'b1;
               end
            end
            append_event(make_event(ostt_pkg::EV_REMOVE_ACK, 32'd0, 8'd0, 1'b0, 1'b1));
         end
         ostt_pkg::ACT_CLEAR: begin
            model_count = 0;
            append_event(make_event(ostt_pkg::EV_CLEAR_ACK, 32'd0, 8'd0, 1'b0, 1'b1));
         end
         default: begin
            // Advance the clock, then fire due entries and compact the survivors.
            model_now = model_now + {16'd0, w.increment_ms};
            for (int i = 0; i < model_count; i++) begin
               gap = model_table[i].deadline - model_now;
               if (!model_table[i].cancelled) begin
                  if ($signed(gap) <= 0) begin
                     append_event(make_event(ostt_pkg::EV_FIRED, model_table[i].ident,
                                             model_table[i].tag, 1'b0, 1'b0));
                  end else begin
                     model_table[keep] = model_table[i];
                     keep++;
                  end
               end
            end
            model_count = keep;
            append_event(make_event(ostt_pkg::EV_TICK_DONE, 32'd0, 8'd0, 1'b0, 1'b1));
         end
      endcase
   endtask

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(input string what);
      $display("%0t: event mismatch, %s", $time, what);
      mismatch_count++;
   endtask

   // Appends one word to the queue of pending words.
   task automatic queue_word(input logic [1:0] act, input logic [15:0] inc,
                             input logic [30:0] dur, input logic [7:0] kind,
                             input logic [31:0] target);
      ostt_pkg::req_type w;
      w.action       = act;
      w.increment_ms = inc;
      w.duration_ms  = dur;
      w.timer_kind   = kind;
      w.target_id    = target;
      pending_words.insert(pending_words.size(), w);
   endtask

   // Request driver: a word is taken at an edge where valid is high and stall is low.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (!req_valid || !req_stall) begin
            if (req_valid) begin
               predict_events(req_word);
               accepted_words <= accepted_words + 1;
            end
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle[phase]) begin
               req_word  <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         phase <= (accepted_words * 3 >= 2 * TOTAL_ITEMS) ? 2 :
                  (accepted_words * 3 >= TOTAL_ITEMS) ? 1 : 0;
      end
   end

   // Response monitor: checks each accepted event against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event kind %0d id %0d",
                                         rsp_word.event_kind, rsp_word.event_id));
            end else begin
               want_event = expected_events.pop_front();
               if (rsp_word.event_kind !== want_event.event_kind)
                  report_mismatch($sformatf("event_kind got %0d want %0d",
                                            rsp_word.event_kind, want_event.event_kind));
               if (rsp_word.event_id !== want_event.event_id)
                  report_mismatch($sformatf("event_id got %0d want %0d",
                                            rsp_word.event_id, want_event.event_id));
               if (rsp_word.event_type !== want_event.event_type)
                  report_mismatch($sformatf("event_type got %0d want %0d",
                                            rsp_word.event_type, want_event.event_type));
               if (rsp_word.time_now !== want_event.time_now)
                  report_mismatch($sformatf("time_now got %0d want %0d",
                                            rsp_word.time_now, want_event.time_now));
               if (rsp_word.table_full !== want_event.table_full)
                  report_mismatch($sformatf("table_full got %0b want %0b",
                                            rsp_word.table_full, want_event.table_full));
               if (rsp_word.last !== want_event.last)
                  report_mismatch($sformatf("last got %0b want %0b",
                                            rsp_word.last, want_event.last));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle[phase]);
      end
   end

   // Stimulus: directed words first, then random traffic, then the final verdict.
   initial begin : stimulus
      ostt_pkg::req_type w;
      int                pick;

      // Tick on an empty table, sets at both extremes, removes with and without a match.
      queue_word(ostt_pkg::ACT_TICK,   16'd0,    31'd0,         8'd0,  32'd0);
      queue_word(ostt_pkg::ACT_SET,    16'd0,    31'd0,         8'd0,  32'd0);
      queue_word(ostt_pkg::ACT_SET,    16'hFFFF, 31'h7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_word(ostt_pkg::ACT_REMOVE, 16'd0,    31'd0,         8'd0,  32'd2);
      queue_word(ostt_pkg::ACT_REMOVE, 16'd0,    31'd0,         8'd0,  32'd2);
      queue_word(ostt_pkg::ACT_REMOVE, 16'hFFFF, 31'h7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_word(ostt_pkg::ACT_REMOVE, 16'd0,    31'd0,         8'd0,  32'd0);
      // Largest increment: the cancelled entry is dropped, the long timer stays.
      queue_word(ostt_pkg::ACT_TICK,   16'hFFFF, 31'd0,         8'd0,  32'd0);
      queue_word(ostt_pkg::ACT_CLEAR,  16'd0,    31'd0,         8'd0,  32'd0);
      // Fill the table, overflow it once, then fire every entry in one tick.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         queue_word(ostt_pkg::ACT_SET, 16'd0, 31'd0, 8'(i * 17), 32'd0);
      end
      queue_word(ostt_pkg::ACT_SET,    16'd0,    31'd5,         8'h5A, 32'd0);
      queue_word(ostt_pkg::ACT_TICK,   16'd0,    31'd0,         8'd0,  32'd0);

      // Random traffic, generated just ahead of the driver so removes can hit live IDs.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         while (pending_words.size() >= 2) @(negedge clock);
         w.increment_ms = 16'($urandom);
         w.duration_ms  = 31'($urandom);
         w.timer_kind   = 8'($urandom);
         w.target_id    = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            w.action = ostt_pkg::ACT_SET;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               w.duration_ms = 31'($urandom_range(0, 200000));
            end else if (pick < 85) begin
               w.duration_ms = 31'($urandom_range(0, 3000));
            end
         end else if (pick < 70) begin
            w.action = ostt_pkg::ACT_TICK;
            if ($urandom_range(0, 9) == 0) begin
               w.increment_ms = 16'd0;
            end
         end else if (pick < 92) begin
            w.action = ostt_pkg::ACT_REMOVE;
            if (model_count > 0 && $urandom_range(0, 99) < 75) begin
               w.target_id = model_table[$urandom_range(0, model_count - 1)].ident;
            end else if ($urandom_range(0, 1) == 0) begin
               w.target_id = model_last_id + 32'd1;
            end
         end else begin
            w.action = ostt_pkg::ACT_CLEAR;
         end
         pending_words.insert(pending_words.size(), w);
      end

      // Drain: every word taken, every event seen, then a quiet spell for strays.
      while (pending_words.size() != 0 || req_valid) @(negedge clock);
      while (expected_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog for a block that hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule
